// ===== design/tlpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared constants and codes for the three-level strict priority queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int unsigned LEVEL_DEPTH_DEF = 16;
  localparam int unsigned NUM_LEVELS      = 3;
  localparam int unsigned DATA_W          = 8;
  localparam int unsigned PRI_W           = 2;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPRI = 2'd3
  } status_t;

  // priority code that names no level
  localparam logic [PRI_W-1:0] PRI_NONE = 2'd0;

endpackage
`default_nettype wire

// ===== design/three_level_priority_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_level_priority_queue_unit
// Three byte FIFOs sharing one store, strict priority on dequeue.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry a command in in_tuser (0 enqueue, 1 dequeue) and a
//   priority and byte in in_tdata. Enqueue appends the byte to level 1..3;
//   dequeue pops the head of the lowest-numbered non-empty level. Every
//   input word yields exactly one output word: the popped byte (else 0) on
//   out_tdata and a status on out_tuser (ok, level full, all empty, bad
//   priority).
//   From acceptance a word passes the read stage (synchronous store read)
//   and then the output register before out_tvalid. One word per cycle is
//   sustained while out_tready stays high; head, tail and fill counts live
//   in flops and are updated at acceptance, so back-to-back pushes and pops
//   need no interlock. The store has one port, used at most once per word.
//   Reset empties all levels (counts and pointers cleared); store contents
//   are not cleared and are only read after being written.
//   When out_tready is low the output register and the read stage hold; up
//   to two words are buffered before in_tready drops.
// ----------------------------------------------------------------------------
module three_level_priority_queue_unit #(
  parameter int unsigned LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [1:0] priority_req, [9:2] data_in, zero pad
  input  wire logic        in_tuser,   // [0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] data_out
  output logic [1:0]       out_tuser   // [1:0] status
);

  localparam int unsigned NL     = tlpq_pkg::NUM_LEVELS;
  localparam int unsigned PTR_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned MEM_D  = NL * LEVEL_DEPTH;
  localparam int unsigned ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LEVEL_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LEVEL_DEPTH);

  logic [tlpq_pkg::PRI_W-1:0]  in_pri;
  logic [tlpq_pkg::DATA_W-1:0] in_byte;
  assign in_pri  = in_tdata[1:0];
  assign in_byte = in_tdata[9:2];

  logic [PTR_W-1:0] head_r [NL];
  logic [PTR_W-1:0] tail_r [NL];
  logic [CNT_W-1:0] cnt_r  [NL];
  logic [PTR_W-1:0] head_nxt [NL];
  logic [PTR_W-1:0] tail_nxt [NL];
  logic [CNT_W-1:0] cnt_nxt  [NL];

  logic [tlpq_pkg::DATA_W-1:0] mem [MEM_D];
  logic [tlpq_pkg::DATA_W-1:0] rdata_r;

  // read stage and output register
  logic                 s1_valid_r, s1_valid_nxt;
  tlpq_pkg::status_t    s1_status_r, s1_status_nxt;
  logic                 s1_pop_r, s1_pop_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tlpq_pkg::status_t    out_status_r;
  logic [7:0]           out_data_r;

  logic              accept, s1_move;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    logic found;
    found         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;
    s1_status_nxt = tlpq_pkg::ST_OK;
    s1_pop_nxt    = 1'b0;
    for (int l = 0; l < NL; l++) begin
      head_nxt[l] = head_r[l];
      tail_nxt[l] = tail_r[l];
      cnt_nxt[l]  = cnt_r[l];
    end
    if (tlpq_pkg::cmd_t'(in_tuser) == tlpq_pkg::CMD_ENQ) begin
      if (in_pri == tlpq_pkg::PRI_NONE) begin
        s1_status_nxt = tlpq_pkg::ST_BADPRI;
      end else begin
        for (int l = 0; l < NL; l++) begin
          if (in_pri == tlpq_pkg::PRI_W'(l + 1)) begin
            if (cnt_r[l] == CNT_FULL) begin
              s1_status_nxt = tlpq_pkg::ST_FULL;
            end else begin
              mem_we      = accept;
              mem_addr    = ADDR_W'(l * LEVEL_DEPTH) + ADDR_W'(tail_r[l]);
              tail_nxt[l] = (tail_r[l] == PTR_LAST) ? '0 : tail_r[l] + 1'b1;
              cnt_nxt[l]  = cnt_r[l] + 1'b1;
            end
          end
        end
      end
    end else begin
      s1_status_nxt = tlpq_pkg::ST_EMPTY;
      for (int l = 0; l < NL; l++) begin
        if (!found && cnt_r[l] != '0) begin
          found         = 1'b1;
          s1_status_nxt = tlpq_pkg::ST_OK;
          s1_pop_nxt    = 1'b1;
          mem_re        = accept;
          mem_addr      = ADDR_W'(l * LEVEL_DEPTH) + ADDR_W'(head_r[l]);
          head_nxt[l]   = (head_r[l] == PTR_LAST) ? '0 : head_r[l] + 1'b1;
          cnt_nxt[l]    = cnt_r[l] - 1'b1;
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_byte;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NL; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        for (int l = 0; l < NL; l++) begin
          head_r[l] <= head_nxt[l];
          tail_r[l] <= tail_nxt[l];
          cnt_r[l]  <= cnt_nxt[l];
        end
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= s1_status_nxt;
      s1_pop_r    <= s1_pop_nxt;
    end
    if (s1_move) begin
      out_status_r <= s1_status_r;
      out_data_r   <= s1_pop_r ? rdata_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

// ===== bench/tlpq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_checker
// Watches both stream channels of the three-level priority queue, keeps its
// own copy of the three level FIFOs and compares every output word with the
// result expected from the accepted input words, oldest first.
// ----------------------------------------------------------------------------
module tlpq_checker #(
  parameter int unsigned LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] priority_req, [9:2] data_in, zero pad
  input  logic        in_tuser,   // [0] cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] data_out
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [tlpq_pkg::DATA_W-1:0] data;
    tlpq_pkg::status_t           status;
  } queue_result_t;

  logic [tlpq_pkg::DATA_W-1:0] level_bytes [tlpq_pkg::NUM_LEVELS][LEVEL_DEPTH];
  int unsigned       head_idx [tlpq_pkg::NUM_LEVELS];
  int unsigned       tail_idx [tlpq_pkg::NUM_LEVELS];
  int unsigned       level_fill [tlpq_pkg::NUM_LEVELS];
  queue_result_t     expected_words [$];
  int                fails = 0;
  int                pending = 0;

  assign fail_count    = fails;
  assign pending_count = pending;

  // Push to / pop from the shadow FIFOs; returns the word the block owes.
  function automatic queue_result_t apply_queue_op(
      input tlpq_pkg::cmd_t cmd,
      input logic [tlpq_pkg::PRI_W-1:0] pri,
      input logic [tlpq_pkg::DATA_W-1:0] din);
    queue_result_t res;
    int unsigned   lv;
    bit            found;
    res.data   = '0;
    res.status = tlpq_pkg::ST_OK;
    found      = 1'b0;
    if (cmd == tlpq_pkg::CMD_ENQ) begin
      if (pri == tlpq_pkg::PRI_NONE) begin
        res.status = tlpq_pkg::ST_BADPRI;
      end else begin
        lv = pri - 1;
        if (level_fill[lv] >= LEVEL_DEPTH) begin
          res.status = tlpq_pkg::ST_FULL;
        end else begin
          level_bytes[lv][tail_idx[lv]] = din;
          tail_idx[lv] = (tail_idx[lv] + 1 == LEVEL_DEPTH) ? 0 : tail_idx[lv] + 1;
          level_fill[lv]++;
        end
      end
    end else begin
      res.status = tlpq_pkg::ST_EMPTY;
      for (int i = 0; i < tlpq_pkg::NUM_LEVELS; i++) begin
        if (!found && level_fill[i] != 0) begin
          res.data   = level_bytes[i][head_idx[i]];
          head_idx[i] = (head_idx[i] + 1 == LEVEL_DEPTH) ? 0 : head_idx[i] + 1;
          level_fill[i]--;
          res.status = tlpq_pkg::ST_OK;
          found      = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < tlpq_pkg::NUM_LEVELS; i++) begin
        head_idx[i]   = 0;
        tail_idx[i]   = 0;
        level_fill[i] = 0;
      end
      expected_words.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_words.push_back(apply_queue_op(tlpq_pkg::cmd_t'(in_tuser),
                                                in_tdata[1:0], in_tdata[9:2]));
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t: unexpected output word, expected none, got data %02h status %0d",
                   $time, out_tdata, out_tuser);
        end else begin
          want = expected_words.pop_front();
          if (out_tdata !== want.data) begin
            fails++;
            $display("%0t: data_out mismatch, expected %02h, got %02h",
                     $time, want.data, out_tdata);
          end
          if (out_tuser !== want.status) begin
            fails++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_tuser);
          end
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives enqueue and dequeue words into the three-level priority queue with
// random gaps and back-pressure, including a long output stall, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned QDEPTH      = tlpq_pkg::LEVEL_DEPTH_DEF;
  localparam int unsigned RAND_WORDS  = 1930;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef enum int unsigned {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED
  } burst_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [1:0] priority_req, [9:2] data_in, zero pad
  logic        in_tuser;   // [0] cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] data_out
  logic [1:0]  out_tuser;  // [1:0] status
  int          fail_count;
  int          pending_count;
  int unsigned cycles = 0;
  bit          tx_fast = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  three_level_priority_queue_unit #(.LEVEL_DEPTH(QDEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tlpq_checker #(.LEVEL_DEPTH(QDEPTH)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Offer one word after a random gap and hold it until accepted.
  // tvalid is only dropped when a gap follows, so it is never lowered and
  // raised in the same step.
  task automatic send_word(input tlpq_pkg::cmd_t cmd,
                           input logic [tlpq_pkg::PRI_W-1:0] pri,
                           input logic [tlpq_pkg::DATA_W-1:0] dat);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 29) == 0)
      tx_fast = !tx_fast;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, dat, pri};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Bursts that push mostly into one level (toward full), mostly pop (toward empty), or mix.
  task automatic send_random_bursts(input int unsigned quota);
    int unsigned                 sent;
    int unsigned                 len;
    int unsigned                 focus;
    burst_t                      kind;
    tlpq_pkg::cmd_t              cmd;
    logic [tlpq_pkg::PRI_W-1:0]  pri;
    sent = 0;
    while (sent < quota) begin
      kind  = burst_t'($urandom_range(0, 2));
      len   = $urandom_range(8, 48);
      focus = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        case (kind)
          BURST_FILL: begin
            cmd = ($urandom_range(0, 7) != 0) ? tlpq_pkg::CMD_ENQ : tlpq_pkg::CMD_DEQ;
            pri = ($urandom_range(0, 3) != 0) ? focus[tlpq_pkg::PRI_W-1:0]
                                              : tlpq_pkg::PRI_W'($urandom_range(0, 3));
          end
          BURST_DRAIN: begin
            cmd = ($urandom_range(0, 7) != 0) ? tlpq_pkg::CMD_DEQ : tlpq_pkg::CMD_ENQ;
            pri = tlpq_pkg::PRI_W'($urandom_range(0, 3));
          end
          default: begin
            cmd = tlpq_pkg::cmd_t'($urandom_range(0, 1));
            pri = tlpq_pkg::PRI_W'($urandom_range(0, 3));
          end
        endcase
        send_word(cmd, pri, tlpq_pkg::DATA_W'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin : stim_proc
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= tlpq_pkg::CMD_ENQ;
    rst_n     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, bad priority, byte extremes, strict ordering
    send_word(tlpq_pkg::CMD_DEQ, 2'd0, 8'h00);
    send_word(tlpq_pkg::CMD_ENQ, tlpq_pkg::PRI_NONE, 8'hff);
    send_word(tlpq_pkg::CMD_ENQ, tlpq_pkg::PRI_NONE, 8'h00);
    send_word(tlpq_pkg::CMD_ENQ, 2'd3, 8'h00);
    send_word(tlpq_pkg::CMD_ENQ, 2'd2, 8'hff);
    send_word(tlpq_pkg::CMD_ENQ, 2'd1, 8'h5a);
    send_word(tlpq_pkg::CMD_ENQ, 2'd1, 8'ha5);
    send_word(tlpq_pkg::CMD_DEQ, 2'd3, 8'hff);
    send_word(tlpq_pkg::CMD_DEQ, 2'd0, 8'h00);
    send_word(tlpq_pkg::CMD_DEQ, 2'd2, 8'h81);
    send_word(tlpq_pkg::CMD_ENQ, 2'd1, 8'h3c);
    send_word(tlpq_pkg::CMD_ENQ, 2'd3, 8'hc3);
    send_word(tlpq_pkg::CMD_DEQ, 2'd1, 8'h7e);
    send_word(tlpq_pkg::CMD_DEQ, 2'd0, 8'h00);
    send_word(tlpq_pkg::CMD_DEQ, 2'd0, 8'h00);
    send_word(tlpq_pkg::CMD_DEQ, 2'd3, 8'hff);
    send_word(tlpq_pkg::CMD_DEQ, 2'd3, 8'hff);

    send_random_bursts(RAND_WORDS);
    in_tvalid <= 1'b0;

    // one more edge so the checker has counted the last accepted word
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  // Output side: random stalls, no-stall stretches and two long hold-offs
  // while the sender keeps offering, so the block backs up its input.
  initial begin : rx_proc
    int unsigned got;
    int unsigned gap;
    bit          rx_fast;
    got     = 0;
    rx_fast = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (got == 150 || got == 1200)
        gap = HOLD_CYCLES;
      else
        gap = rx_fast ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 29) == 0)
        rx_fast = !rx_fast;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got++;
    end
  end

endmodule

// ===== filelist.f =====
design/tlpq_pkg.sv
design/three_level_priority_queue_unit.sv
bench/tlpq_checker.sv
bench/tb_top.sv
